### src/aes256_pkg.sv
// shared types, tables and round functions for the aes-256 block cipher
`default_nettype none
package aes256_pkg;

    typedef logic [127:0] state_t;
    typedef logic [3:0]   rk_idx_t;

    localparam int      NUM_STAGES = 15;
    localparam rk_idx_t LAST_ROUND = 4'd14;
    localparam rk_idx_t KX_STEPS   = 4'd13;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_KEY_PART0 = 3'd0;
    localparam cfg_idx_t CFG_KEY_PART1 = 3'd1;
    localparam cfg_idx_t CFG_KEY_PART2 = 3'd2;
    localparam cfg_idx_t CFG_KEY_PART3 = 3'd3;
    localparam cfg_idx_t CFG_DIRECTION = 3'd4;

    localparam logic [0:255][7:0] SBOX = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [0:255][7:0] INV_SBOX = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte k of the state sits at bits [127-8k -: 8]
    function automatic state_t sub_shift(input state_t s);
        state_t t;
        int     r;
        int     c;
        t = '0;
        for (c = 0; c < 4; c++) begin
            for (r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
            end
        end
        sub_shift = t;
    endfunction

    function automatic state_t inv_sub_shift(input state_t s);
        state_t t;
        int     r;
        int     c;
        t = '0;
        for (c = 0; c < 4; c++) begin
            for (r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = INV_SBOX[s[127 - 8 * (r + 4 * c) -: 8]];
            end
        end
        inv_sub_shift = t;
    endfunction

    function automatic state_t mix_cols(input state_t s);
        state_t     t;
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        logic [7:0] all;
        int         c;
        t = '0;
        for (c = 0; c < 4; c++) begin
            a0  = s[127 - 32 * c -: 8];
            a1  = s[119 - 32 * c -: 8];
            a2  = s[111 - 32 * c -: 8];
            a3  = s[103 - 32 * c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        mix_cols = t;
    endfunction

    function automatic state_t inv_mix_cols(input state_t s);
        state_t     t;
        logic [7:0] a   [4];
        logic [7:0] m9  [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2;
        logic [7:0] x4;
        logic [7:0] x8;
        int         c;
        int         r;
        t = '0;
        for (c = 0; c < 4; c++) begin
            for (r = 0; r < 4; r++) begin
                a[r]   = s[127 - 8 * (r + 4 * c) -: 8];
                x2     = xtime(a[r]);
                x4     = xtime(x2);
                x8     = xtime(x4);
                m9[r]  = x8 ^ a[r];
                m11[r] = x8 ^ x2 ^ a[r];
                m13[r] = x8 ^ x4 ^ a[r];
                m14[r] = x8 ^ x4 ^ x2;
            end
            t[127 - 32 * c -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
            t[119 - 32 * c -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
            t[111 - 32 * c -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
            t[103 - 32 * c -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
        end
        inv_mix_cols = t;
    endfunction

endpackage
`default_nettype wire

### src/aes256_kx.sv
// key registers and iterative key expansion into per-stage round keys
`default_nettype none
module aes256_kx
    import aes256_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire cfg_idx_t    cfg_addr,
    input  wire logic [63:0] cfg_wdata,
    output logic             busy,
    output logic             decrypt,
    output state_t           stage_key [NUM_STAGES]
);

    logic [63:0]  key_reg [4];
    logic         dir_reg;
    logic         busy_reg;
    logic         busy_next;
    rk_idx_t      step_reg;
    rk_idx_t      step_next;
    logic [255:0] win_reg;
    logic [255:0] win_next;
    state_t       rk_reg [NUM_STAGES];

    logic [31:0]  w7;
    logic [31:0]  t;
    logic [7:0]   rcon;
    logic [31:0]  n0;
    logic [31:0]  n1;
    logic [31:0]  n2;
    logic [31:0]  n3;
    state_t       new_key;
    state_t       first_key;
    state_t       second_key;
    rk_idx_t      rk_num;
    rk_idx_t      dst_idx;
    state_t       dst_data;
    rk_idx_t      dst_first;
    rk_idx_t      dst_second;
    state_t       second_data;
    logic         valid_addr;

    assign valid_addr = (cfg_addr == CFG_KEY_PART0) || (cfg_addr == CFG_KEY_PART1)
                     || (cfg_addr == CFG_KEY_PART2) || (cfg_addr == CFG_KEY_PART3)
                     || (cfg_addr == CFG_DIRECTION);

    always_comb
    begin
        // odd steps follow a multiple of eight words: rotate and add rcon
        w7   = win_reg[31:0];
        rcon = 8'h01 << step_reg[3:1];
        if (step_reg[0])
        begin
            t = sub_word({w7[23:0], w7[31:24]}) ^ {rcon, 24'h000000};
        end
        else
        begin
            t = sub_word(w7);
        end
        n0      = win_reg[255:224] ^ t;
        n1      = win_reg[223:192] ^ n0;
        n2      = win_reg[191:160] ^ n1;
        n3      = win_reg[159:128] ^ n2;
        new_key = {n0, n1, n2, n3};
        rk_num  = step_reg + 4'd1;
        dst_idx = dir_reg ? LAST_ROUND - rk_num : rk_num;
        if (dir_reg && rk_num != LAST_ROUND)
        begin
            dst_data = inv_mix_cols(new_key);
        end
        else
        begin
            dst_data = new_key;
        end

        first_key   = {key_reg[0], key_reg[1]};
        second_key  = {key_reg[2], key_reg[3]};
        dst_first   = dir_reg ? LAST_ROUND : 4'd0;
        dst_second  = dir_reg ? LAST_ROUND - 4'd1 : 4'd1;
        second_data = dir_reg ? inv_mix_cols(second_key) : second_key;

        win_next  = win_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (cfg_we && valid_addr)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                win_next = {first_key, second_key};
            end
            else
            begin
                win_next = {win_reg[127:0], new_key};
            end
            step_next = step_reg + 4'd1;
            if (step_reg == KX_STEPS)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= '0;
            key_reg[1] <= '0;
            key_reg[2] <= '0;
            key_reg[3] <= '0;
            dir_reg    <= 1'b0;
            busy_reg   <= 1'b1;
            step_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_KEY_PART0: key_reg[0] <= cfg_wdata;
                    CFG_KEY_PART1: key_reg[1] <= cfg_wdata;
                    CFG_KEY_PART2: key_reg[2] <= cfg_wdata;
                    CFG_KEY_PART3: key_reg[3] <= cfg_wdata;
                    CFG_DIRECTION: dir_reg    <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (busy_reg && !(cfg_we && valid_addr))
        begin
            for (int m = 0; m < NUM_STAGES; m++)
            begin
                if (step_reg == '0)
                begin
                    if (rk_idx_t'(m) == dst_first)
                    begin
                        rk_reg[m] <= first_key;
                    end
                    else if (rk_idx_t'(m) == dst_second)
                    begin
                        rk_reg[m] <= second_data;
                    end
                end
                else if (rk_idx_t'(m) == dst_idx)
                begin
                    rk_reg[m] <= dst_data;
                end
            end
        end
    end

    assign busy      = busy_reg;
    assign decrypt   = dir_reg;
    assign stage_key = rk_reg;

endmodule
`default_nettype wire

### src/aes256_stage.sv
// one pipeline stage: a cipher or inverse cipher round with its valid bit
`default_nettype none
module aes256_stage
    import aes256_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   ark_only,
    input  wire logic   last_round,
    input  wire logic   decrypt,
    input  wire state_t round_key,
    input  wire logic   in_valid,
    input  wire state_t in_data,
    output logic        ready,
    input  wire logic   down_ready,
    output logic        out_valid,
    output state_t      out_data
);

    logic   valid_reg;
    state_t data_reg;
    state_t data_next;
    state_t sub_data;
    state_t mix_data;

    always_comb
    begin
        sub_data = decrypt ? inv_sub_shift(in_data) : sub_shift(in_data);
        if (last_round)
        begin
            mix_data = sub_data;
        end
        else if (decrypt)
        begin
            mix_data = inv_mix_cols(sub_data);
        end
        else
        begin
            mix_data = mix_cols(sub_data);
        end
        data_next = (ark_only ? in_data : mix_data) ^ round_key;
    end

    // a stage takes a beat when empty or when its own beat moves on
    assign ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

### src/aes256_ecb_block_cipher_top.sv
// aes-256 ecb block cipher: fifteen-stage round pipeline and key expansion
// one stage per round plus the first key add, each stage registering its result
// throughput: one block per cycle unless m_tready or the key expansion stalls the pipeline
// after reset and after each configuration write to a valid address the key expansion runs
// with s_tready low; the pipeline resets empty and the key registers reset to zero
`default_nettype none
module aes256_ecb_block_cipher_top
    import aes256_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [63:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // block_high [63:0], block_low [127:64]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata    // result_high [63:0], result_low [127:64]
);

    logic   kx_busy;
    logic   decrypt;
    state_t stage_key  [NUM_STAGES];
    state_t stage_data [NUM_STAGES];
    logic   [NUM_STAGES-1:0] stage_valid;
    logic   [NUM_STAGES-1:0] stage_ready;
    state_t in_state;

    aes256_kx u_kx (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .busy      (kx_busy),
        .decrypt   (decrypt),
        .stage_key (stage_key)
    );

    assign in_state = {s_tdata[63:0], s_tdata[127:64]};
    assign s_tready = !kx_busy && stage_ready[0];

    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_stage
        aes256_stage u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .ark_only   (g == 0),
            .last_round (g == NUM_STAGES - 1),
            .decrypt    (decrypt),
            .round_key  (stage_key[g]),
            .in_valid   ((g == 0) ? (s_tvalid && !kx_busy) : stage_valid[(g == 0) ? 0 : g - 1]),
            .in_data    ((g == 0) ? in_state : stage_data[(g == 0) ? 0 : g - 1]),
            .ready      (stage_ready[g]),
            .down_ready ((g == NUM_STAGES - 1) ? m_tready
                         : stage_ready[(g == NUM_STAGES - 1) ? g : g + 1]),
            .out_valid  (stage_valid[g]),
            .out_data   (stage_data[g])
        );
    end

    assign m_tvalid = stage_valid[NUM_STAGES-1];
    assign m_tdata  = {stage_data[NUM_STAGES-1][63:0], stage_data[NUM_STAGES-1][127:64]};

endmodule
`default_nettype wire

### bench/tb_top.sv
// testbench for the aes-256 ecb block cipher: directed vectors, key sweeps, random blocks
`default_nettype none
module tb_top;
    import aes256_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [63:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;

    aes256_ecb_block_cipher_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predictor copy of the registers
    logic [63:0] key_regs [4];
    logic        decrypt_mode;

    logic [127:0] expected_blocks [$];
    int           mismatch_count;
    int           idle_cycles;
    bit           sink_stall_on;

    logic [7:0] sbox_tab [256];
    logic [7:0] inv_sbox_tab [256];

    initial
    begin
        logic [127:0] rows [16];
        rows = '{128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
                 128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
                 128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
                 128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
                 128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
                 128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
                 128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
                 128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};
        for (int i = 0; i < 256; i++)
        begin
            sbox_tab[i] = rows[i / 16][127 - 8 * (i % 16) -: 8];
        end
        for (int i = 0; i < 256; i++)
        begin
            inv_sbox_tab[sbox_tab[i]] = i[7:0];
        end
    end

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                r ^= a;
            end
            a = gf_double(a);
        end
        return r;
    endfunction

    // bytes as an array, byte 0 first
    function automatic logic [127:0] cipher_block(input logic [127:0] blk);
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  s [16];
        logic [7:0]  n [16];
        logic [7:0]  a0;
        logic [7:0]  a1;
        logic [7:0]  a2;
        logic [7:0]  a3;
        logic [7:0]  rc;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 8; i++)
        begin
            w[i] = key_regs[i / 2][(i % 2 == 0) ? 63 : 31 -: 32];
        end
        for (int i = 8; i < 60; i++)
        begin
            t = w[i - 1];
            if (i % 8 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {sbox_tab[t[31:24]], sbox_tab[t[23:16]], sbox_tab[t[15:8]], sbox_tab[t[7:0]]};
                t[31:24] ^= rc;
                rc = gf_double(rc);
            end
            else if (i % 8 == 4)
            begin
                t = {sbox_tab[t[31:24]], sbox_tab[t[23:16]], sbox_tab[t[15:8]], sbox_tab[t[7:0]]};
            end
            w[i] = w[i - 8] ^ t;
        end
        for (int k = 0; k < 16; k++)
        begin
            s[k] = blk[127 - 8 * k -: 8];
        end
        if (!decrypt_mode)
        begin
            for (int k = 0; k < 16; k++) s[k] ^= w[k / 4][31 - 8 * (k % 4) -: 8];
            for (int rnd = 1; rnd <= 14; rnd++)
            begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        n[r + 4 * c] = sbox_tab[s[r + 4 * ((c + r) % 4)]];
                if (rnd != 14)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        a0 = n[4 * c]; a1 = n[4 * c + 1]; a2 = n[4 * c + 2]; a3 = n[4 * c + 3];
                        n[4 * c]     = gf_mul(a0, 8'd2) ^ gf_mul(a1, 8'd3) ^ a2 ^ a3;
                        n[4 * c + 1] = a0 ^ gf_mul(a1, 8'd2) ^ gf_mul(a2, 8'd3) ^ a3;
                        n[4 * c + 2] = a0 ^ a1 ^ gf_mul(a2, 8'd2) ^ gf_mul(a3, 8'd3);
                        n[4 * c + 3] = gf_mul(a0, 8'd3) ^ a1 ^ a2 ^ gf_mul(a3, 8'd2);
                    end
                end
                for (int k = 0; k < 16; k++)
                    s[k] = n[k] ^ w[4 * rnd + k / 4][31 - 8 * (k % 4) -: 8];
            end
        end
        else
        begin
            for (int k = 0; k < 16; k++) s[k] ^= w[56 + k / 4][31 - 8 * (k % 4) -: 8];
            for (int rnd = 13; rnd >= 0; rnd--)
            begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        n[r + 4 * ((c + r) % 4)] = inv_sbox_tab[s[r + 4 * c]];
                for (int k = 0; k < 16; k++)
                    s[k] = n[k] ^ w[4 * rnd + k / 4][31 - 8 * (k % 4) -: 8];
                if (rnd != 0)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
                        s[4 * c]     = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11)
                                     ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
                        s[4 * c + 1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14)
                                     ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
                        s[4 * c + 2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9)
                                     ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
                        s[4 * c + 3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13)
                                     ^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
                    end
                end
            end
        end
        for (int k = 0; k < 16; k++)
        begin
            res[127 - 8 * k -: 8] = s[k];
        end
        return res;
    endfunction

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // result side: random stalls while sink_stall_on is set, compare each beat with the oldest expectation
    initial
    begin
        int stall;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = sink_stall_on ? $urandom_range(0, 10) : 0;
            m_tready = 1'b0;
            repeat (stall) @(negedge clk);
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            check_result(m_tdata);
        end
    end

    task automatic check_result(input logic [127:0] got);
        logic [127:0] want;
        logic [63:0]  got_hi;
        logic [63:0]  got_lo;
        logic [63:0]  want_hi;
        logic [63:0]  want_lo;
        if (expected_blocks.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result beat %h", got);
            return;
        end
        want = expected_blocks.pop_front();
        // result_high sits in the low half of tdata, block bytes 0..7 there
        got_hi = got[63:0];
        got_lo = got[127:64];
        want_hi = want[127:64];
        want_lo = want[63:0];
        if (got_hi !== want_hi || got_lo !== want_lo)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch: result_high exp %h got %h, result_low exp %h got %h",
                         want_hi, got_hi, want_lo, got_lo);
        end
    endtask

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic send_block(input logic [127:0] blk, input bit with_gaps);
        int gap;
        gap = with_gaps ? $urandom_range(0, 10) : 0;
        repeat (gap) @(negedge clk);
        s_tdata = {blk[63:0], blk[127:64]};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        expected_blocks.push_back(cipher_block(blk));
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
        wait (expected_blocks.size() == 0);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_KEY_PART0: key_regs[0] = value;
            CFG_KEY_PART1: key_regs[1] = value;
            CFG_KEY_PART2: key_regs[2] = value;
            CFG_KEY_PART3: key_regs[3] = value;
            CFG_DIRECTION: decrypt_mode = value[0];
            default: ;
        endcase
    endtask

    task automatic load_key(input logic [255:0] key, input logic [63:0] dir);
        write_reg(CFG_KEY_PART0, key[255:192]);
        write_reg(CFG_KEY_PART1, key[191:128]);
        write_reg(CFG_KEY_PART2, key[127:64]);
        write_reg(CFG_KEY_PART3, key[63:0]);
        write_reg(CFG_DIRECTION, dir);
    endtask

    function automatic logic [127:0] rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // fips-197 appendix c.3 vector, both directions, plus field extremes at reset key
    task automatic test_directed();
        logic [255:0] key;
        key = 256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f;
        send_block('0, 1'b0);
        send_block('1, 1'b0);
        send_block({64'h0, 64'hffffffffffffffff}, 1'b0);
        load_key(key, 64'd0);
        send_block(128'h00112233445566778899aabbccddeeff, 1'b0);
        send_block(128'haaaaaaaaaaaaaaaa5555555555555555, 1'b0);
        // upper direction bits are ignored
        load_key(key, 64'hfffffffffffffffe);
        send_block('1, 1'b0);
        load_key(key, 64'h8000000000000001);
        send_block(128'h8ea2b7ca516745bfeafc49904b496089, 1'b0);
        send_block('0, 1'b0);
        load_key('1, 64'd1);
        send_block('1, 1'b0);
        send_block('0, 1'b0);
        load_key('1, 64'd0);
        send_block('1, 1'b0);
        // writes to unused indexes change nothing
        write_reg(cfg_idx_t'(5), '1);
        write_reg(cfg_idx_t'(7), '1);
        send_block(128'h0123456789abcdeffedcba9876543210, 1'b0);
    endtask

    task automatic test_random_keys();
        for (int phase = 0; phase < 10; phase++)
        begin
            load_key({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom}, {$urandom, $urandom});
            sink_stall_on = (phase % 3 != 2);
            for (int i = 0; i < 160; i++)
                send_block(rand_block(), (phase % 3 != 2) && (i % 40 < 30));
        end
        sink_stall_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        load_key('0, 64'd1);
        sink_stall_on = 1'b0;
        for (int i = 0; i < 40; i++)
            send_block(rand_block(), 1'b0);
        sink_stall_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        key_regs = '{default: '0};
        decrypt_mode = 1'b0;
        mismatch_count = 0;
        idle_cycles = 0;
        sink_stall_on = 1'b1;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_keys();
        test_back_to_back();
        wait (expected_blocks.size() == 0);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_blocks.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
